// ----- rtl/mwrf_pkg.sv -----
// shared types, constants and the crc step for the modbus write register framer
package mwrf_pkg;

   // frame layout
   localparam int unsigned FRAME_LEN = 8;
   localparam int unsigned BYTE_IDX_W = $clog2(FRAME_LEN);
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // byte positions within the frame
   localparam logic [BYTE_IDX_W-1:0] POS_ADDR = 3'd0;
   localparam logic [BYTE_IDX_W-1:0] POS_FUNC = 3'd1;
   localparam logic [BYTE_IDX_W-1:0] POS_REG_HI = 3'd2;
   localparam logic [BYTE_IDX_W-1:0] POS_REG_LO = 3'd3;
   localparam logic [BYTE_IDX_W-1:0] POS_CMD = 3'd4;
   localparam logic [BYTE_IDX_W-1:0] POS_DELAY = 3'd5;
   localparam logic [BYTE_IDX_W-1:0] POS_CRC_LO = 3'd6;
   localparam logic [BYTE_IDX_W-1:0] POS_CRC_HI = 3'd7;

   // protocol constants
   localparam logic [7:0] FUNC_WRITE_SINGLE = 8'h06;
   localparam logic [7:0] REG_HIGH_BYTE = 8'h00;
   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;
   localparam logic [7:0] SLAVE_ADDR_RESET = 8'h01;

   // request item
   typedef struct packed {
      logic [7:0] register_low;
      logic [7:0] command_byte;
      logic [7:0] delay_byte;
   } req_type;

   // result item
   typedef struct packed {
      logic [7:0] frame_byte;
      logic       last_byte;
   } rsp_type;

   // queued job: request plus the address captured at accept time
   typedef struct packed {
      logic [7:0] slave_address;
      req_type    req;
   } job_type;

   // queue head as seen by the back part
   typedef struct packed {
      logic    valid;
      job_type job;
   } head_type;

   // one byte through the reflected crc-16 shifter
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] acc;
      acc = crc ^ {8'h00, data};
      for (int b = 0; b < 8; b++) begin
         if (acc[0]) begin
            acc = (acc >> 1) ^ CRC_POLY;
         end else begin
            acc = acc >> 1;
         end
      end
      return acc;
   endfunction

endpackage

// ----- rtl/mwrf_front.sv -----
// front part: address register and a two-entry request queue
module mwrf_front import mwrf_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     csr_we,
   input  logic [7:0] csr_wdata,
   input  logic     push,
   output logic     full,
   input  req_type  req_data,
   output head_type head,
   input  logic     head_pop
);

   logic [7:0]             slave_addr_ff;
   job_type                slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                   do_push, do_pop;

   // address register
   always_ff @(posedge clock) begin
      if (reset) begin
         slave_addr_ff <= SLAVE_ADDR_RESET;
      end else if (csr_we) begin
         slave_addr_ff <= csr_wdata;
      end
   end

   assign full    = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign do_push = push && !full;
   assign do_pop  = head_pop && (count_ff != '0);

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= '{slave_address: slave_addr_ff, req: req_data};
      end
   end

   assign head.valid = (count_ff != '0);
   assign head.job   = slot_ff[rd_ptr_ff];

endmodule

// ----- rtl/mwrf_back.sv -----
// back part: byte sequencer, running crc and the result register
module mwrf_back import mwrf_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  head_type head,
   output logic     head_pop,
   output logic     empty,
   input  logic     pop,
   output rsp_type  rsp_data
);

   logic [BYTE_IDX_W-1:0] pos_ff, pos_in;
   logic [15:0]           crc_ff, crc_in;
   logic                  out_valid_ff, out_valid_in;
   rsp_type               out_ff, out_in;
   logic                  advance, load;
   logic [7:0]            cur_byte;
   logic [15:0]           crc_base;

   // result register frees when empty or being taken
   assign advance = !out_valid_ff || pop;
   assign load    = advance && head.valid;

   // select the frame byte for the current position
   always_comb begin
      case (pos_ff)
         POS_ADDR:   cur_byte = head.job.slave_address;
         POS_FUNC:   cur_byte = FUNC_WRITE_SINGLE;
         POS_REG_HI: cur_byte = REG_HIGH_BYTE;
         POS_REG_LO: cur_byte = head.job.req.register_low;
         POS_CMD:    cur_byte = head.job.req.command_byte;
         POS_DELAY:  cur_byte = head.job.req.delay_byte;
         POS_CRC_LO: cur_byte = crc_ff[7:0];
         POS_CRC_HI: cur_byte = crc_ff[15:8];
         default:    cur_byte = '0;
      endcase
   end

   // crc accumulates over the six header bytes
   always_comb begin
      crc_base = (pos_ff == POS_ADDR) ? CRC_INIT : crc_ff;
      crc_in   = crc_ff;
      if (load && (pos_ff inside {[POS_ADDR:POS_DELAY]})) begin
         crc_in = crc_byte(crc_base, cur_byte);
      end
   end

   // position counter and result register
   always_comb begin
      pos_in       = load ? pos_ff + 1'b1 : pos_ff;
      head_pop     = load && (pos_ff == POS_CRC_HI);
      out_valid_in = advance ? head.valid : out_valid_ff;
      out_in       = out_ff;
      if (load) begin
         out_in.frame_byte = cur_byte;
         out_in.last_byte  = (pos_ff == POS_CRC_HI);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      crc_ff <= crc_in;
      out_ff <= out_in;
   end

   assign empty    = !out_valid_ff;
   assign rsp_data = out_ff;

endmodule

// ----- rtl/modbus_write_register_framer_top.sv -----
// top level of the modbus rtu write single register framer
//
// Requests enter through a queue-style port: req_data is taken at a clock
// edge with push high and full low. Each request becomes an eight-byte
// frame: slave address, function 0x06, register high 0x00, register low,
// command, delay, then the crc-16/modbus low and high bytes. Bytes leave
// through rsp_data, one item per byte; the oldest is valid while empty is
// low and is taken at an edge with pop high. last_byte marks the crc high.
// The slave address is written through csr_we/csr_wdata and is captured
// with each request when it is accepted.
// Each accepted request is stored in the queue; the back part then loads
// its frame bytes one by one into the result register. Throughput: one
// byte per cycle while pop is held high, set by the single byte sequencer.
// A two-entry request queue lets new requests in while a frame is still
// being sent; full rises once the queue holds two requests, the one being sent included.
// Reset clears the queue and the output, and sets the address to 1.
// When the receiver holds pop low the current byte stays in place and the
// sequencer waits; no byte is dropped.
module modbus_write_register_framer_top import mwrf_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_we,
   input  logic [7:0] csr_wdata,
   input  logic       push,
   output logic       full,
   input  req_type    req_data,
   output logic       empty,
   input  logic       pop,
   output rsp_type    rsp_data
);

   head_type head;
   logic     head_pop;

   // request capture and queue
   mwrf_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .push      (push),
      .full      (full),
      .req_data  (req_data),
      .head      (head),
      .head_pop  (head_pop)
   );

   // frame sequencer
   mwrf_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .head_pop (head_pop),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

endmodule
